@@ hdl/mrwt_pkg.sv @@
// Shared types and constants for the Miller-Rabin witness test block.
package mrwt_pkg;

  localparam int unsigned FIELD_BITS     = 64;
  localparam int unsigned WORD_BITS_DEF  = 64;
  localparam int unsigned IN_TDATA_BITS  = 2 * FIELD_BITS;
  localparam int unsigned OUT_TDATA_BITS = 8;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_DIV,
    DP_SPLIT,
    DP_INIT_POW,
    DP_MUL_XB,
    DP_MUL_BB,
    DP_MUL_XX,
    DP_MUL_STEP,
    DP_MUL_WB,
    DP_SHIFT_E
  } dp_cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_DIV,
    ST_SPLIT,
    ST_POW,
    ST_POW_SQ,
    ST_MUL,
    ST_CHECK,
    ST_SQ_CHK,
    ST_FINISH
  } ctl_state_e;

  typedef struct packed {
    logic trivial;      // n < 2 or n even
    logic trivial_res;  // n == 2
    logic div_done;
    logic q_lsb;
    logic q_zero;
    logic q_one;
    logic mul_done;
    logic x_one;
    logic x_nm1;
    logic s_le1;
  } dp_status_t;

endpackage

@@ hdl/mrwt_dp.sv @@
// Datapath: witness modulo, n-1 split, add-and-double modular multiply.
module mrwt_dp #(
  parameter int unsigned W = mrwt_pkg::WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  mrwt_pkg::dp_cmd_e    cmd_i,
  input  logic [W-1:0]         cand_i,
  input  logic [W-1:0]         rand_i,
  output mrwt_pkg::dp_status_t status_o
);
  import mrwt_pkg::*;

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  n_q, r_q, rem_q, q_q, x_q, b_q, mx_q, my_q, acc_q;
  logic [CW-1:0] cnt_q, s_q;
  logic          tgt_x_q;
  logic [W-1:0]  nm1;
  logic [W:0]    trial;
  logic [W-1:0]  rem_nxt;

  // (a + b) mod m for a, b < m
  function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                           input logic [W-1:0] m);
    logic [W:0] sum;
    logic [W:0] dif;
    sum = {1'b0, a} + {1'b0, b};
    dif = sum - {1'b0, m};
    add_mod = (sum >= {1'b0, m}) ? dif[W-1:0] : sum[W-1:0];
  endfunction

  assign nm1     = n_q - W'(1);
  // restoring division, one dividend bit per cycle
  assign trial   = {rem_q, r_q[W-1]};
  assign rem_nxt = (trial >= {1'b0, nm1}) ? W'(trial - {1'b0, nm1}) : trial[W-1:0];

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      DP_LOAD: begin
        n_q   <= cand_i;
        r_q   <= rand_i;
        rem_q <= '0;
        cnt_q <= CW'(W);
        q_q   <= cand_i - W'(1);
        s_q   <= '0;
      end
      DP_DIV: begin
        r_q   <= r_q << 1;
        rem_q <= rem_nxt;
        cnt_q <= cnt_q - 1'b1;
      end
      DP_SPLIT: begin
        q_q <= q_q >> 1;
        s_q <= s_q + 1'b1;
      end
      DP_INIT_POW: begin
        x_q <= W'(1);
        b_q <= rem_q + W'(1);
      end
      DP_MUL_XB: begin
        mx_q    <= x_q;
        my_q    <= b_q;
        acc_q   <= '0;
        tgt_x_q <= 1'b1;
      end
      DP_MUL_BB: begin
        mx_q    <= b_q;
        my_q    <= b_q;
        acc_q   <= '0;
        tgt_x_q <= 1'b0;
        q_q     <= q_q >> 1;
      end
      DP_MUL_XX: begin
        mx_q    <= x_q;
        my_q    <= x_q;
        acc_q   <= '0;
        tgt_x_q <= 1'b1;
        s_q     <= s_q - 1'b1;
      end
      DP_MUL_STEP: begin
        if (mx_q[0]) begin
          acc_q <= add_mod(acc_q, my_q, n_q);
        end
        mx_q <= mx_q >> 1;
        my_q <= add_mod(my_q, my_q, n_q);
      end
      DP_MUL_WB: begin
        if (tgt_x_q) begin
          x_q <= acc_q;
        end else begin
          b_q <= acc_q;
        end
      end
      DP_SHIFT_E: begin
        q_q <= q_q >> 1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    status_o.trivial     = (n_q[W-1:1] == '0) || !n_q[0];
    status_o.trivial_res = (n_q == W'(2));
    status_o.div_done    = (cnt_q == '0);
    status_o.q_lsb       = q_q[0];
    status_o.q_zero      = (q_q == '0);
    status_o.q_one       = (q_q == W'(1));
    status_o.mul_done    = (mx_q == '0);
    status_o.x_one       = (x_q == W'(1));
    status_o.x_nm1       = (x_q == nm1);
    status_o.s_le1       = (s_q <= CW'(1));
  end

endmodule

@@ hdl/mrwt_ctrl.sv @@
// Controller: sequences the datapath and holds the result word register.
module mrwt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 out_flag_o,
  output mrwt_pkg::dp_cmd_e    cmd_o,
  input  mrwt_pkg::dp_status_t status_i
);
  import mrwt_pkg::*;

  ctl_state_e state_q, state_d;
  ctl_state_e ret_q, ret_d;
  logic       res_q, res_d;
  logic       out_valid_q, out_valid_d;
  logic       out_flag_q, out_flag_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      res_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_flag_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      out_flag_q  <= out_flag_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    res_d       = res_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_flag_d  = out_flag_q;
    cmd_o       = DP_NOP;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = DP_LOAD;
          state_d = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        if (status_i.trivial) begin
          res_d   = status_i.trivial_res;
          state_d = ST_FINISH;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          state_d = ST_SPLIT;
        end else begin
          cmd_o = DP_DIV;
        end
      end
      ST_SPLIT: begin
        if (status_i.q_lsb) begin
          cmd_o   = DP_INIT_POW;
          state_d = ST_POW;
        end else begin
          cmd_o = DP_SPLIT;
        end
      end
      ST_POW: begin
        if (status_i.q_zero) begin
          state_d = ST_CHECK;
        end else if (status_i.q_lsb) begin
          cmd_o   = DP_MUL_XB;
          ret_d   = ST_POW_SQ;
          state_d = ST_MUL;
        end else begin
          state_d = ST_POW_SQ;
        end
      end
      ST_POW_SQ: begin
        // last exponent bit done: the final base squaring is not needed
        if (status_i.q_one) begin
          cmd_o   = DP_SHIFT_E;
          state_d = ST_CHECK;
        end else begin
          cmd_o   = DP_MUL_BB;
          ret_d   = ST_POW;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (status_i.mul_done) begin
          cmd_o   = DP_MUL_WB;
          state_d = ret_q;
        end else begin
          cmd_o = DP_MUL_STEP;
        end
      end
      ST_CHECK: begin
        if (status_i.x_one || status_i.x_nm1) begin
          res_d   = 1'b1;
          state_d = ST_FINISH;
        end else if (status_i.s_le1) begin
          res_d   = 1'b0;
          state_d = ST_FINISH;
        end else begin
          cmd_o   = DP_MUL_XX;
          ret_d   = ST_SQ_CHK;
          state_d = ST_MUL;
        end
      end
      ST_SQ_CHK: begin
        if (status_i.x_nm1) begin
          res_d   = 1'b1;
          state_d = ST_FINISH;
        end else if (status_i.s_le1) begin
          res_d   = 1'b0;
          state_d = ST_FINISH;
        end else begin
          cmd_o   = DP_MUL_XX;
          ret_d   = ST_SQ_CHK;
          state_d = ST_MUL;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_flag_d  = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_flag_o  = out_flag_q;

endmodule

@@ hdl/miller_rabin_witness_test.sv @@
// Sequence per word: n < 2 and even n are settled by the classify step alone; otherwise the
// witness remainder r mod (n-1) is computed, n-1 is split as q*2^s, and x = b^q mod n
// follows, with b the remainder plus one, using at most 2*WORD_BITS-3 serial add-and-double
// multiplies, then the squaring checks of x against 1 and n-1.
// One word at a time, set by the single shared modular multiplier;
// a new word is taken once the result is in the output register.
// Reset (rst_ni low, asynchronous) returns to idle and drops the output word.
module miller_rabin_witness_test #(
  parameter int unsigned WORD_BITS = mrwt_pkg::WORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [63:0] candidate, [127:64] random_word
  input  logic [mrwt_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [0] probable_prime, [7:1] zero
  output logic [mrwt_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata_o
);
  import mrwt_pkg::*;

  dp_cmd_e          cmd;
  dp_status_t       status;
  logic             flag;
  logic [WORD_BITS-1:0] cand, rnd;

  assign cand = s_axis_tdata_i[WORD_BITS-1:0];
  assign rnd  = s_axis_tdata_i[FIELD_BITS+WORD_BITS-1:FIELD_BITS];

  mrwt_dp #(
    .W (WORD_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .cmd_i    (cmd),
    .cand_i   (cand),
    .rand_i   (rnd),
    .status_o (status)
  );

  mrwt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_flag_o  (flag),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  assign m_axis_tdata_o = {{(OUT_TDATA_BITS-1){1'b0}}, flag};

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted while a word is in work");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result word appeared without an item in work");

  a_no_cmd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tready_o && !s_axis_tvalid_i) |-> (cmd == DP_NOP))
    else $error("datapath commanded while idle");
`endif

endmodule
